>>> rtl/core/plst_pkg.sv
// shared types, request codes and field widths for the positional list store
package plst_pkg;

  // default sizing
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;

  // request codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ   = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // per-cycle command broadcast along the cell row
  typedef enum logic [2:0] {
    CMD_HOLD   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_DELETE = 3'd2,
    CMD_WRITE  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } cell_ctrl_t;

  // registered result
  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] data_out;
    logic [LEN_W-1:0]   length;
    logic               is_empty;
  } result_t;

endpackage

>>> rtl/core/plst_cell.sv
// one list cell: holds an entry and shifts with its neighbors
module plst_cell #(
  parameter int INDEX  = 0,
  parameter int CELL_W = 32,
  parameter int PW     = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plst_pkg::cell_ctrl_t ctrl,
  input  logic [CELL_W-1:0]    left_data,
  input  logic [CELL_W-1:0]    right_data,
  output logic [CELL_W-1:0]    data
);
  import plst_pkg::*;

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic [PW-1:0]     pos_w;
  logic [CELL_W-1:0] data_r;
  logic [CELL_W-1:0] data_nxt;

  assign pos_w = PW'(ctrl.pos);

  // next entry from the broadcast command and the position compare
  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.cmd)
      CMD_HOLD: data_nxt = data_r;
      CMD_INSERT: begin
        if (IDX > pos_w) begin
          data_nxt = left_data;
        end else if (IDX == pos_w) begin
          data_nxt = ctrl.value[CELL_W-1:0];
        end
      end
      CMD_DELETE: begin
        if (IDX >= pos_w) begin
          data_nxt = right_data;
        end
      end
      CMD_WRITE: begin
        if (IDX == pos_w) begin
          data_nxt = ctrl.value[CELL_W-1:0];
        end
      end
      CMD_CLEAR: data_nxt = '0;
      default:   data_nxt = data_r;
    endcase
  end

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule

>>> rtl/core/plst_ctrl.sv
// request decode, range checks, entry count and result register
module plst_ctrl #(
  parameter int CAPACITY = 16,
  parameter int CW       = 5,
  parameter int PW       = 5,
  parameter int CELL_W   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [plst_pkg::OP_W-1:0]      op,
  input  logic [plst_pkg::POS_W-1:0]     position,
  input  logic [plst_pkg::VALUE_W-1:0]   value,
  input  logic [CELL_W-1:0]              rd_data,
  input  logic                           out_stall,
  output plst_pkg::cell_ctrl_t           cell_ctrl,
  output plst_pkg::result_t              result,
  output logic                           out_valid
);
  import plst_pkg::*;

  localparam logic [PW-1:0] CAP = PW'(CAPACITY);

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [PW-1:0]      pos_w;
  logic [PW-1:0]      cnt_w;
  logic [PW-1:0]      cnt_nxt_w;
  status_t            status;
  logic [VALUE_W-1:0] data;
  cmd_t               cmd;
  result_t            result_r;
  result_t            result_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;

  assign pos_w = PW'(position);
  assign cnt_w = PW'(count_r);

  // decode and range check
  always_comb begin
    status    = ST_OK;
    data      = '0;
    cmd       = CMD_HOLD;
    count_nxt = count_r;
    unique case (op)
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          status = ST_RANGE;
        end else if (cnt_w >= CAP) begin
          status = ST_FULL;
        end else begin
          cmd       = CMD_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          data      = VALUE_W'(rd_data);
          cmd       = CMD_DELETE;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_READ: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          data = VALUE_W'(rd_data);
        end
      end
      OP_WRITE: begin
        if (pos_w >= cnt_w) begin
          status = ST_RANGE;
        end else begin
          cmd = CMD_WRITE;
        end
      end
      OP_CLEAR: begin
        cmd       = CMD_CLEAR;
        count_nxt = '0;
      end
      default: begin
        cmd = CMD_HOLD;
      end
    endcase
  end

  // command to the cell row, only for an accepted request
  assign cell_ctrl.cmd   = accept ? cmd : CMD_HOLD;
  assign cell_ctrl.pos   = position;
  assign cell_ctrl.value = value;

  // result assembly
  assign cnt_nxt_w = PW'(count_nxt);
  always_comb begin
    result_nxt.status   = status;
    result_nxt.data_out = data;
    result_nxt.length   = cnt_nxt_w[LEN_W-1:0];
    result_nxt.is_empty = (count_nxt == '0);
  end

  // output valid: set by a request, dropped once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
    end
  end

  assign result    = result_r;
  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/positional_list_store.sv
// top level: ordered list held in a row of shifting cells
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_op, in_position, in_value
//   out_     output     out_valid/out_stall out_status, out_data_out, out_length, out_is_empty
//
// For each accepted request, all cells shift together against the position
// compare, and the result is registered at the same edge the cells update.
// A result appears in the cycle after its request is accepted.
// Reset clears all cells, the entry count and the output valid at once.
// A new request is taken while out_stall is low or no result is pending.
module positional_list_store #(
  parameter int CAPACITY   = plst_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = plst_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [plst_pkg::OP_W-1:0]       in_op,
  input  logic [plst_pkg::POS_W-1:0]      in_position,
  input  logic [plst_pkg::VALUE_W-1:0]    in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [plst_pkg::STATUS_W-1:0]   out_status,
  output logic [plst_pkg::VALUE_W-1:0]    out_data_out,
  output logic [plst_pkg::LEN_W-1:0]      out_length,
  output logic                            out_is_empty
);
  import plst_pkg::*;

  localparam int CELL_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int IW     = $clog2(CAPACITY);
  localparam int PW     = (CW > POS_W) ? CW : POS_W;

  logic              accept;
  cell_ctrl_t        cell_ctrl;
  result_t           result;
  logic [CELL_W-1:0] cell_data [CAPACITY];
  logic [PW-1:0]     pos_w;
  logic [IW-1:0]     rd_idx;
  logic [CELL_W-1:0] rd_data;

  // handshake
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // read select at the request position
  assign pos_w   = PW'(in_position);
  assign rd_idx  = pos_w[IW-1:0];
  assign rd_data = cell_data[rd_idx];

  plst_ctrl #(
    .CAPACITY (CAPACITY),
    .CW       (CW),
    .PW       (PW),
    .CELL_W   (CELL_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_op),
    .position  (in_position),
    .value     (in_value),
    .rd_data   (rd_data),
    .out_stall (out_stall),
    .cell_ctrl (cell_ctrl),
    .result    (result),
    .out_valid (out_valid)
  );

  // cell row, ends tied to zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [CELL_W-1:0] left_data;
    logic [CELL_W-1:0] right_data;
    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[i+1];
    end
    plst_cell #(
      .INDEX  (i),
      .CELL_W (CELL_W),
      .PW     (PW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i])
    );
  end

  // result ports
  assign out_status   = result.status;
  assign out_data_out = result.data_out;
  assign out_length   = result.length;
  assign out_is_empty = result.is_empty;

endmodule

>>> rtl/core/plst_checker.sv
// port-level checks for the positional list store, bound to the top level
module plst_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [plst_pkg::OP_W-1:0]     in_op,
  input logic                          out_valid,
  input logic [plst_pkg::STATUS_W-1:0] out_status,
  input logic [plst_pkg::VALUE_W-1:0]  out_data_out,
  input logic [plst_pkg::LEN_W-1:0]    out_length,
  input logic                          out_is_empty
);
  import plst_pkg::*;

  // an accepted request always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  // a clear request empties the list
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == OP_CLEAR) |=>
      (out_length == '0 && out_is_empty && out_status == ST_OK))
    else $error("clear did not empty the list");

  // empty flag tracks the reported length
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_length == '0)))
    else $error("empty flag disagrees with length");

  // failed requests return no data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_data_out == '0))
    else $error("failed request returned data");

  // no undefined status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_RANGE || out_status == ST_FULL))
    else $error("undefined status code");

endmodule

bind positional_list_store plst_checker u_plst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_op        (in_op),
  .out_valid    (out_valid),
  .out_status   (out_status),
  .out_data_out (out_data_out),
  .out_length   (out_length),
  .out_is_empty (out_is_empty)
);
